@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL; only the line queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define A_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");
`define A_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define A_NEVER(lbl, cond)
`define A_IMPL(lbl, ante, cons)
`endif
`endif

@@ rtl/imu_lsa_pkg.sv @@
`timescale 1ns / 1ps
package imu_lsa_pkg;
  localparam int unsigned MAX_PERIOD  = 1000;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned NUM_Q       = 10;
  localparam int unsigned PER_W       = 10;
  localparam int unsigned SUM_W       = SAMPLE_BITS + $clog2(MAX_PERIOD + 1);
  localparam int unsigned NUM_W       = SUM_W + 24;
  localparam int unsigned DEN_W       = 16 + PER_W;
  localparam int unsigned IDX_W       = $clog2(NUM_Q);
  localparam int unsigned STEP_W      = $clog2(NUM_W);

  localparam logic [1:0] REG_MASK   = 2'd0;
  localparam logic [1:0] REG_ARANGE = 2'd1;
  localparam logic [1:0] REG_GRANGE = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  localparam int unsigned GRP_ACCEL = 0;
  localparam int unsigned GRP_GYRO  = 1;
  localparam int unsigned GRP_MAG   = 2;
  localparam int unsigned GRP_TEMP  = 3;

  typedef logic [NUM_Q-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic  valid;
    sums_t sums;
  } line_t;

  typedef struct packed {
    logic [3:0]       mask;
    logic [1:0]       accel_range;
    logic [1:0]       gyro_range;
    logic [PER_W-1:0] period;
  } cfg_t;

  // Enable group of a quantity: ids run accel xyz, gyro xyz, mag xyz, temperature.
  function automatic logic [1:0] group_of(input logic [IDX_W-1:0] id);
    logic [1:0] g;
    if (id < IDX_W'(3))      g = 2'(GRP_ACCEL);
    else if (id < IDX_W'(6)) g = 2'(GRP_GYRO);
    else if (id < IDX_W'(9)) g = 2'(GRP_MAG);
    else                     g = 2'(GRP_TEMP);
    return g;
  endfunction

  // Input slot of a quantity; temperature sits fourth in the raw line.
  function automatic logic [IDX_W-1:0] src_of(input logic [IDX_W-1:0] id);
    logic [IDX_W-1:0] s;
    if (id < IDX_W'(3))      s = id;
    else if (id < IDX_W'(9)) s = id + IDX_W'(1);
    else                     s = IDX_W'(3);
    return s;
  endfunction
endpackage

@@ rtl/imu_lsa_front.sv @@
`timescale 1ns / 1ps
module imu_lsa_front import imu_lsa_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic                        restart_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [NUM_Q*SAMPLE_BITS-1:0] s_axis_tdata_i,
  input  logic                        full_i,
  output logic                        push_o,
  output sums_t                       push_sums_o
);
  sums_t            sums_q, sums_d;
  logic [PER_W-1:0] count_q, count_d;
  logic [PER_W:0]   count_inc;
  logic             accept, emit;

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o && (cfg_i.period != '0);
  assign count_inc       = {1'b0, count_q} + (PER_W+1)'(1);
  assign emit            = count_inc >= {1'b0, cfg_i.period};

  always_comb begin
    for (int i = 0; i < NUM_Q; i++) begin
      logic [IDX_W-1:0] s;
      s = src_of(IDX_W'(i));
      if (cfg_i.mask[group_of(IDX_W'(i))]) begin
        sums_d[i] = sums_q[i] + SUM_W'($signed(s_axis_tdata_i[s*SAMPLE_BITS +: SAMPLE_BITS]));
      end else begin
        sums_d[i] = sums_q[i];
      end
    end
    count_d = count_inc[PER_W-1:0];
  end

  assign push_o      = accept && emit && (cfg_i.mask != '0);
  assign push_sums_o = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q  <= '0;
      count_q <= '0;
    end else if (restart_i) begin
      sums_q  <= '0;
      count_q <= '0;
    end else if (accept) begin
      if (emit) begin
        sums_q  <= '0;
        count_q <= '0;
      end else begin
        sums_q  <= sums_d;
        count_q <= count_d;
      end
    end
  end
endmodule

@@ rtl/imu_lsa_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module imu_lsa_queue import imu_lsa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  sums_t push_sums_i,
  output logic  full_o,
  input  logic  pop_i,
  output line_t head_o
);
  sums_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o      = cnt_q == 2'd2;
  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.sums  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_sums_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `A_NEVER(a_no_overflow, push_i && full_o && !pop_i)
  `A_NEVER(a_no_underflow, pop_i && !head_o.valid)
  `A_IMPL(a_count_bound, 1'b1, cnt_q != 2'd3)
endmodule

@@ rtl/imu_lsa_back.sv @@
`timescale 1ns / 1ps
module imu_lsa_back import imu_lsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  line_t       head_i,
  output logic        pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  typedef enum logic [2:0] {ST_IDLE, ST_SEEK, ST_PREP, ST_DIV, ST_OUT} state_e;

  state_e                   state_q;
  logic [IDX_W-1:0]         idx_q;
  logic [NUM_W-1:0]         num_q;
  logic [DEN_W-1:0]         den_q, rem_q;
  logic                     neg_q;
  logic [STEP_W-1:0]        step_q;
  logic                     out_valid_q, out_last_q;
  logic [31:0]              out_value_q;
  logic [3:0]               out_id_q;

  logic signed [NUM_W-1:0]  s_ext, num_s;
  logic [DEN_W-1:0]         den_d, n_ext;
  logic [1:0]               grp;
  logic [DEN_W+1:0]         trial;
  logic                     qbit;
  logic [DEN_W-1:0]         rem_d;
  logic [31:0]              sat_value;
  logic                     is_last;
  logic [3:0]               higher;

  assign grp   = group_of(idx_q);
  assign s_ext = NUM_W'($signed(head_i.sums[idx_q]));
  assign n_ext = DEN_W'(cfg_i.period);

  always_comb begin
    num_s = s_ext <<< 2;
    den_d = n_ext;
    unique case (grp)
      2'(GRP_ACCEL): begin
        num_s = s_ext <<< (3'd2 + 3'(cfg_i.accel_range));
        den_d = n_ext;
      end
      2'(GRP_GYRO): begin
        unique case (cfg_i.gyro_range)
          2'd0: begin num_s = s_ext <<< 16; den_d = n_ext * DEN_W'(131); end
          2'd1: begin num_s = s_ext <<< 17; den_d = n_ext * DEN_W'(131); end
          2'd2: begin num_s = (s_ext * NUM_W'(5)) <<< 16; den_d = n_ext * DEN_W'(164); end
          default: begin num_s = (s_ext * NUM_W'(10)) <<< 16; den_d = n_ext * DEN_W'(164); end
        endcase
      end
      2'(GRP_MAG): begin
        num_s = s_ext <<< 2;
        den_d = n_ext;
      end
      default: begin
        num_s = (s_ext * NUM_W'(100) + NUM_W'(n_ext) * NUM_W'(1242020)) <<< 16;
        den_d = n_ext * DEN_W'(34000);
      end
    endcase
  end

  // One restoring division step: the numerator shifts out on top, the quotient in below.
  assign trial = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
  assign qbit  = !trial[DEN_W+1];
  assign rem_d = qbit ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], num_q[NUM_W-1]};

  always_comb begin
    if (neg_q) begin
      sat_value = (num_q > NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : (32'd0 - num_q[31:0]);
    end else begin
      sat_value = (num_q > NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : num_q[31:0];
    end
  end

  always_comb begin
    unique case (grp)
      2'(GRP_ACCEL): higher = 4'b1110;
      2'(GRP_GYRO):  higher = 4'b1100;
      2'(GRP_MAG):   higher = 4'b1000;
      default:       higher = 4'b0000;
    endcase
  end
  assign is_last = (idx_q == IDX_W'(2) || idx_q == IDX_W'(5) || idx_q == IDX_W'(8)
                    || idx_q == IDX_W'(9)) && ((cfg_i.mask & higher) == 4'b0000);

  assign pop_o = (state_q == ST_SEEK) && (idx_q == IDX_W'(NUM_Q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_value_q <= '0;
      out_id_q    <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != ST_OUT)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (head_i.valid) state_q <= ST_SEEK;
        end
        ST_SEEK: begin
          if (idx_q == IDX_W'(NUM_Q)) begin
            idx_q   <= '0;
            state_q <= ST_IDLE;
          end else if (cfg_i.mask[grp]) begin
            state_q <= ST_PREP;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_PREP: begin
          neg_q   <= num_s[NUM_W-1];
          num_q   <= num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
          den_q   <= den_d;
          rem_q   <= '0;
          step_q  <= STEP_W'(NUM_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= rem_d;
          num_q  <= {num_q[NUM_W-2:0], qbit};
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= sat_value;
            out_id_q    <= 4'(idx_q);
            out_last_q  <= is_last;
            idx_q       <= idx_q + IDX_W'(1);
            state_q     <= ST_SEEK;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_id_q;
  assign m_axis_tlast_o  = out_last_q;
endmodule

@@ rtl/imu_line_scale_average_unit.sv @@
// Throughput: one line per cycle while the two-entry line queue is not full; an averaged
// line takes up to ten divisions in the shared restoring divider of the back end.
// A two-entry line queue lets the front keep accumulating while the back divides.
// Reset (asynchronous, active low) clears registers, sums, count and queue.
`timescale 1ns / 1ps
module imu_line_scale_average_unit import imu_lsa_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [PER_W-1:0]             cfg_data_i,
  // Raw lines. tdata: accel_x, accel_y, accel_z, die_temp, gyro_x, gyro_y, gyro_z,
  // mag_x, mag_y, mag_z, 16 bits each from the lowest bit up.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [NUM_Q*SAMPLE_BITS-1:0] s_axis_tdata_i,
  // Results. tdata: value (Q16.16). tuser: quantity_id.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [31:0]                  m_axis_tdata_o,
  output logic [3:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  logic [3:0]       mask_q;
  logic [1:0]       arange_q, grange_q;
  logic [PER_W-1:0] period_q;
  cfg_t             cfg;
  logic             restart, push, full, pop;
  sums_t            push_sums;
  line_t            head;

  // Writing the mask or the period restarts the running average.
  assign restart = cfg_we_i && (cfg_idx_i == REG_MASK || cfg_idx_i == REG_PERIOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      arange_q <= '0;
      grange_q <= '0;
      period_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MASK:   mask_q   <= cfg_data_i[3:0];
        REG_ARANGE: arange_q <= cfg_data_i[1:0];
        REG_GRANGE: grange_q <= cfg_data_i[1:0];
        default:    period_q <= cfg_data_i;
      endcase
    end
  end

  // Periods beyond the supported maximum are clamped.
  always_comb begin
    cfg.mask        = mask_q;
    cfg.accel_range = arange_q;
    cfg.gyro_range  = grange_q;
    cfg.period      = ({1'b0, period_q} > (PER_W+1)'(MAX_PERIOD)) ? PER_W'(MAX_PERIOD)
                                                                : period_q;
  end

  imu_lsa_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .restart_i(restart),
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .full_i(full), .push_o(push), .push_sums_o(push_sums)
  );

  imu_lsa_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_sums_i(push_sums),
    .full_o(full), .pop_i(pop), .head_o(head)
  );

  imu_lsa_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .head_i(head), .pop_o(pop),
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tlast_o
  );
endmodule

@@ tb/sv/imu_line_scale_average_unit_tb.sv @@
`timescale 1ns / 1ps
module imu_line_scale_average_unit_tb;
  import imu_lsa_pkg::*;

  // Quantity ids on the result side: accel xyz, gyro xyz, mag xyz, then temperature.
  localparam int unsigned QID_GYRO_X = 3;
  localparam int unsigned QID_MAG_X  = 6;
  localparam int unsigned QID_TEMP   = 9;
  // Input slot of the die temperature inside a raw line.
  localparam int unsigned SLOT_TEMP  = 3;

  // Idle schemes of the stimulus phases.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  // Cycles waited after the last expected value before the block is known to be quiet:
  // the back-end divider handles a full ten-value line one value at a time.
  localparam int unsigned QUIET_CYCLES = 700;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  qid;
    logic        last;
  } scaled_value_t;

  typedef logic signed [15:0] raw_line_t [NUM_Q];

  // Mirrors the averager: its own copy of the registers, the running sums and
  // the line count, plus the queue of averaged values still to come out.
  class average_scoreboard;
    logic [3:0]     mask;
    logic [1:0]     accel_rng;
    logic [1:0]     gyro_rng;
    logic [9:0]     period;
    longint         sums [NUM_Q];
    logic [9:0]     lines;
    scaled_value_t  due_values [$];
    int             failures;

    function void clear_sums();
      foreach (sums[i]) sums[i] = 0;
      lines = '0;
    endfunction

    function void reset();
      mask = '0;
      accel_rng = '0;
      gyro_rng = '0;
      period = '0;
      clear_sums();
      due_values.delete();
      failures = 0;
    endfunction

    // Range writes keep the sums; mask and period writes restart the average.
    function void write_reg(logic [1:0] idx, logic [9:0] data);
      case (idx)
        REG_MASK: begin
          mask = data[3:0];
          clear_sums();
        end
        REG_ARANGE: accel_rng = data[1:0];
        REG_GRANGE: gyro_rng = data[1:0];
        REG_PERIOD: begin
          period = data;
          clear_sums();
        end
        default: ;
      endcase
    endfunction

    function int unsigned group_of_qid(int unsigned q);
      if (q < QID_GYRO_X) return GRP_ACCEL;
      if (q < QID_MAG_X) return GRP_GYRO;
      if (q < QID_TEMP) return GRP_MAG;
      return GRP_TEMP;
    endfunction

    // The mean times the gain, taken as one exact fraction in Q16.16 and
    // truncated toward zero, then clamped to 32 bits.
    function logic [31:0] scaled_mean(int unsigned q, longint total, longint n);
      longint num, den, quo;
      if (q < QID_GYRO_X) begin
        num = total * (longint'(4) << accel_rng);
        den = n;
      end else if (q < QID_MAG_X) begin
        case (gyro_rng)
          2'd0: begin num = total * 65536;  den = 131 * n; end
          2'd1: begin num = total * 131072; den = 131 * n; end
          2'd2: begin num = total * 327680; den = 164 * n; end
          default: begin num = total * 655360; den = 164 * n; end
        endcase
      end else if (q < QID_TEMP) begin
        num = total * 4;
        den = n;
      end else begin
        num = (100 * total + 1242020 * n) * 65536;
        den = 34000 * n;
      end
      quo = num / den;
      if (quo > 64'sd2147483647) quo = 64'sd2147483647;
      if (quo < -64'sd2147483648) quo = -64'sd2147483648;
      return quo[31:0];
    endfunction

    function void note_line(raw_line_t line);
      longint eff;
      int unsigned slot;
      int unsigned last_k;
      scaled_value_t v;
      scaled_value_t batch [$];
      if (period == 0) return;
      eff = (period > MAX_PERIOD) ? MAX_PERIOD : period;
      for (int unsigned q = 0; q < NUM_Q; q++) begin
        slot = (q < QID_GYRO_X) ? q : (q < QID_TEMP) ? q + 1 : SLOT_TEMP;
        if (mask[group_of_qid(q)]) sums[q] += longint'(line[slot]);
      end
      lines = lines + 10'd1;
      if (longint'(lines) < eff) return;
      for (int unsigned q = 0; q < NUM_Q; q++) begin
        if (mask[group_of_qid(q)]) begin
          v.value = scaled_mean(q, sums[q], eff);
          v.qid = q[3:0];
          v.last = 1'b0;
          batch.push_back(v);
        end
        sums[q] = 0;
      end
      if (batch.size() > 0) begin
        last_k = batch.size() - 1;
        batch[last_k].last = 1'b1;
      end
      foreach (batch[i]) due_values.push_back(batch[i]);
      lines = '0;
    endfunction

    function void check_value(logic [31:0] value, logic [3:0] qid, logic last);
      scaled_value_t e;
      if (due_values.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected value %h qid %0d last %0d", value, qid, last);
        return;
      end
      e = due_values.pop_front();
      if (e.value !== value || e.qid !== qid || e.last !== last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected %h qid %0d last %0d, got %h qid %0d last %0d",
                   e.value, e.qid, e.last, value, qid, last);
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [1:0]                   cfg_idx_i;
  logic [PER_W-1:0]             cfg_data_i;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [NUM_Q*SAMPLE_BITS-1:0] s_axis_tdata_i;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [31:0]                  m_axis_tdata_o;
  logic [3:0]                   m_axis_tuser_o;
  logic                         m_axis_tlast_o;

  imu_line_scale_average_unit dut (.*);

  average_scoreboard sb;
  idle_e idle_mode;
  bit    hold_request;
  bit    run_done;
  int    random_lines;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random stalls per the idle scheme, plus one long hold-off
  // counted here so the block fills up and pushes back on its input.
  initial begin
    int unsigned hold_left;
    int unsigned stall_pct;
    hold_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 83 : (idle_mode == IDLE_BOTH) ? 29 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every result transaction is checked against the oldest expected value.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_value(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  end

  // Watchdog on the whole run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (!run_done) begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One register write; the task returns with the write enable low again.
  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [3:0] mask, logic [1:0] ar, logic [1:0] gr,
                           logic [9:0] per);
    write_reg(REG_MASK, 10'(mask));
    write_reg(REG_ARANGE, 10'(ar));
    write_reg(REG_GRANGE, 10'(gr));
    write_reg(REG_PERIOD, per);
  endtask

  // Offers one raw line and returns once the input transaction has happened.
  // tvalid stays high so lines can follow back to back.
  task automatic send_line(raw_line_t line);
    int unsigned gap_pct;
    logic [NUM_Q*SAMPLE_BITS-1:0] packed_line;
    gap_pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 29 : 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    foreach (line[k]) packed_line[k*SAMPLE_BITS +: SAMPLE_BITS] = line[k];
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= packed_line;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_line(line);
  endtask

  // Stops offering and waits until every expected value is out and the
  // back end has had time to finish any line that yields nothing.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_values.size() > 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic raw_line_t random_line();
    raw_line_t line;
    foreach (line[k]) line[k] = random_sample();
    return line;
  endfunction

  function automatic raw_line_t flat_line(logic signed [15:0] s);
    raw_line_t line;
    foreach (line[k]) line[k] = s;
    return line;
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_line(random_line());
  endtask

  initial begin
    raw_line_t line;
    logic [9:0] per;
    sb = new();
    sb.reset();
    idle_mode       = IDLE_NONE;
    hold_request    = 1'b0;
    run_done        = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all quantities at full scale, zero, minus one, mixed; a line each.
    configure(4'hF, 2'd0, 2'd0, 10'd1);
    send_line(flat_line(16'sh7FFF));
    send_line(flat_line(16'sh8000));
    send_line(flat_line(16'sh0000));
    send_line(flat_line(16'shFFFF));
    foreach (line[k]) line[k] = (k % 2) ? 16'sh5555 : 16'shAAAA;
    send_line(line);
    drain();

    // Widest gains, averaged over two lines.
    configure(4'hF, 2'd3, 2'd3, 10'd2);
    send_line(flat_line(16'sh7FFF));
    send_line(flat_line(16'sh7FFF));
    send_line(flat_line(16'sh8000));
    send_line(flat_line(16'sh8000));
    drain();

    // Middle gyro ranges with a period of three; a range change leaves sums alone.
    configure(4'hA, 2'd1, 2'd1, 10'd3);
    send_random(2);
    drain();
    write_reg(REG_GRANGE, 10'd2);
    send_random(4);
    drain();

    // Stopped: lines are dropped and nothing comes out.
    configure(4'hF, 2'd2, 2'd0, 10'd0);
    send_random(3);
    drain();

    // Empty mask: lines are counted but yield nothing.
    configure(4'h0, 2'd0, 2'd0, 10'd1);
    send_random(3);
    drain();

    // Period above the limit: a short run of lines stays below it and yields nothing.
    configure(4'h5, 2'd3, 2'd0, 10'd1023);
    send_random(20);
    drain();

    // Random phases, rotating through the idle schemes.
    random_lines = 0;
    while (random_lines < 270) begin
      idle_mode = idle_e'((random_lines / 30) % 4);
      case ($urandom_range(9))
        0: per = 10'd0;
        1: per = 10'($urandom_range(9, 40));
        default: per = 10'($urandom_range(1, 8));
      endcase
      configure(4'($urandom_range(15)), 2'($urandom), 2'($urandom), per);
      send_random(30);
      random_lines += 30;
      drain();
    end

    // Long receiver hold-off while lines keep coming, so the input stalls.
    idle_mode = IDLE_NONE;
    configure(4'hF, 2'd1, 2'd3, 10'd1);
    hold_request = 1'b1;
    send_random(12);
    drain();

    run_done = 1'b1;
    if (sb.failures == 0 && sb.due_values.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ imu_line_scale_average_unit.f @@
+incdir+rtl
rtl/imu_lsa_pkg.sv
rtl/imu_lsa_front.sv
rtl/imu_lsa_queue.sv
rtl/imu_lsa_back.sv
rtl/imu_line_scale_average_unit.sv
tb/sv/imu_line_scale_average_unit_tb.sv
